FILE: rtl/core/pst_pkg.sv
// ============================================================================
// pst_pkg - shared types and constants of the prefix sum tree
// command and result word layouts, command codes, register map constants
// ============================================================================
`default_nettype none

package pst_pkg;

    // default number of tree slots
    localparam int DEF_MAX_SLOTS = 1024;

    // register map
    localparam int          SIZE_W          = 11;
    localparam int          PADDR_W         = 3;
    localparam int          PDATA_W         = 32;
    localparam logic        REG_TREE_SIZE   = 1'b0;
    localparam logic [10:0] TREE_SIZE_RESET = 11'd1024;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic        [1:0]  command;
        logic        [9:0]  index;
        logic signed [31:0] delta;
    } t_cmd_word;

    typedef struct packed {
        logic signed [63:0] prefix_sum;
        logic               status;
    } t_result_word;

endpackage

`default_nettype wire

FILE: rtl/core/pst_ram.sv
// ============================================================================
// pst_ram - generic simple dual port ram
// one write port, one read port, registered read data
// ============================================================================
`default_nettype none

module pst_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/prefix_sum_tree_top.sv
// ============================================================================
// prefix_sum_tree_top - binary indexed tree of signed 64-bit counters
// add at a slot, prefix sum query and clear, over one shared 64-bit adder
// ============================================================================
//
// usage
//   command channel: a word (command, index, delta) is taken at a rising edge
//   with start high and busy low. every word gives exactly one result word,
//   shown on o_result for one cycle with o_result_valid high; the receiver
//   cannot stall, so results are never held back
//   an add or query walks the tree one node a cycle through the node ram:
//   the read of the next node is issued while the current one is summed and,
//   on an add, written back, so an item keeps busy high while it walks and
//   its result appears in the cycle after its last node; no new item is taken
//   until the walk is done. rejected words, a query at slot zero and the
//   unused command give their result the next cycle with busy staying low
//   clear: a sweep writes zero to every node, one a cycle, then gives the
//   result word
//   reset: the same clearing pass runs without a result; busy is high
//   meanwhile. the apb port takes writes at any time
//   apb: tree_size at byte address 0, pready always high
//
`default_nettype none

module prefix_sum_tree_top #(
    parameter int MAX_SLOTS = pst_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command channel
    input  wire logic                        start,
    output logic                             busy,
    input  wire pst_pkg::t_cmd_word          i_cmd,
    // result channel
    output logic                             o_result_valid,
    output pst_pkg::t_result_word            o_result,
    // apb configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pst_pkg::PADDR_W-1:0] paddr,
    input  wire logic [pst_pkg::PDATA_W-1:0] pwdata,
    output logic      [pst_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);

    import pst_pkg::*;

    // node address, walk position (holds pos + lowbit), size compare width
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW = AW + 1;
    localparam int SW = (PW > SIZE_W) ? PW : SIZE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_CLEAR
    } t_state;

    t_state               r_state, n_state;
    logic [PW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_clr, n_clr;
    logic                 r_clr_report, n_clr_report;
    logic                 r_is_add, n_is_add;
    logic [63:0]          r_amount, n_amount;
    logic [63:0]          r_acc, n_acc;
    logic                 r_result_valid, n_result_valid;
    t_result_word         r_result, n_result;
    logic [SIZE_W-1:0]    r_tree_size;

    // ram side
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [63:0]          ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [63:0]          ram_rdata;

    // datapath
    logic [SW-1:0]        eff_size;
    logic [SW-1:0]        idx_ext;
    logic [PW-1:0]        start_pos;
    logic [PW-1:0]        low_bit;
    logic [PW-1:0]        pos_up;
    logic [PW-1:0]        pos_dn;
    logic [PW-1:0]        pos_next;
    logic                 walk_more;
    logic [63:0]          add_sum;
    logic                 accept;
    logic                 cfg_write;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_size <= TREE_SIZE_RESET;
        end else if (cfg_write && (paddr[2] == REG_TREE_SIZE)) begin
            r_tree_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TREE_SIZE) ?
                    {{(PDATA_W-SIZE_W){1'b0}}, r_tree_size} : '0;

    // size in use, limited to the slots actually built
    always_comb begin
        if (SW'(r_tree_size) > SW'(MAX_SLOTS)) begin
            eff_size = SW'(MAX_SLOTS);
        end else begin
            eff_size = SW'(r_tree_size);
        end
    end

    assign idx_ext   = SW'(i_cmd.index);
    assign start_pos = PW'(i_cmd.index);
    assign accept    = start && !busy;

    // ------------------------------------------------------------------
    // walk step: lowest set bit, next node up or down
    // ------------------------------------------------------------------
    assign low_bit  = r_pos & (~r_pos + 1'b1);
    assign pos_up   = r_pos + low_bit;
    assign pos_dn   = r_pos - low_bit;
    assign pos_next = r_is_add ? pos_up : pos_dn;
    assign walk_more = r_is_add ? (SW'(pos_up) < eff_size) : (pos_dn != '0);

    // the one shared adder: node plus delta on an add, node plus running sum
    // on a query
    assign add_sum = ram_rdata + (r_is_add ? r_amount : r_acc);

    // ------------------------------------------------------------------
    // ram port control
    // ------------------------------------------------------------------
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[AW-1:0];
        ram_wdata = add_sum;
        ram_raddr = start_pos[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                // first node read goes out with the accepting edge
                ram_raddr = start_pos[AW-1:0];
            end
            S_WALK: begin
                ram_we    = r_is_add;
                ram_raddr = pos_next[AW-1:0];
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    pst_ram #(
        .WIDTH (64),
        .DEPTH (MAX_SLOTS)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        n_clr          = r_clr;
        n_clr_report   = r_clr_report;
        n_is_add       = r_is_add;
        n_amount       = r_amount;
        n_acc          = r_acc;
        n_result_valid = 1'b0;
        n_result       = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos                = start_pos;
                    n_amount             = {{32{i_cmd.delta[31]}}, i_cmd.delta};
                    n_acc                = '0;
                    n_result.prefix_sum  = '0;
                    n_result.status      = 1'b0;
                    unique case (i_cmd.command)
                        CMD_ADD: begin
                            n_is_add = 1'b1;
                            if ((i_cmd.index == '0) || (idx_ext >= eff_size)) begin
                                n_result.status = 1'b1;
                                n_result_valid  = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        CMD_QUERY: begin
                            n_is_add = 1'b0;
                            if (i_cmd.index == '0) begin
                                // empty sum
                                n_result_valid = 1'b1;
                            end else if (idx_ext >= eff_size) begin
                                n_result.status = 1'b1;
                                n_result_valid  = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        CMD_CLEAR: begin
                            n_clr        = '0;
                            n_clr_report = 1'b1;
                            n_state      = S_CLEAR;
                        end
                        default: begin
                            // unused command, plain done
                            n_result_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                n_acc = add_sum;
                n_pos = pos_next;
                if (!walk_more) begin
                    n_state             = S_IDLE;
                    n_result_valid      = 1'b1;
                    n_result.status     = 1'b0;
                    n_result.prefix_sum = r_is_add ? '0 : add_sum;
                end
            end
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(MAX_SLOTS - 1)) begin
                    n_state             = S_IDLE;
                    n_result_valid      = r_clr_report;
                    n_result.status     = 1'b0;
                    n_result.prefix_sum = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset starts a silent clearing pass
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_clr_report   <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr          <= n_clr;
            r_clr_report   <= n_clr_report;
            r_result_valid <= n_result_valid;
        end
        r_pos    <= n_pos;
        r_is_add <= n_is_add;
        r_amount <= n_amount;
        r_acc    <= n_acc;
        r_result <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR) && !r_clr_report)
        else $error("reset did not start a clearing pass");

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy || r_result_valid)
        else $error("accepted word neither started nor answered");

    a_add_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && r_is_add |-> (r_pos != '0) && (SW'(r_pos) < eff_size))
        else $error("add walk left the tree");

    a_query_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && !r_is_add |-> (r_pos != '0))
        else $error("query walk reached slot zero");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result_valid && r_result.status |-> (r_result.prefix_sum == '0))
        else $error("rejected word carries a sum");

endmodule

`default_nettype wire

FILE: test/tb_prefix_sum_tree_top.sv
// ============================================================================
// tb_prefix_sum_tree_top - self-checking bench for the prefix sum tree
// adds, prefix sum queries, clears and the unused command are driven over
// the start/busy channel, checked against an in-bench fenwick tree model;
// tree_size is swept through its extremes over the apb port between phases
// ============================================================================

module tb_prefix_sum_tree_top;

    import pst_pkg::*;

    localparam int NUM_SLOTS       = DEF_MAX_SLOTS;
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 4000000;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 103;

    // the fourth command code, which the block should ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // byte address of tree_size on the apb port
    localparam logic [PADDR_W-1:0] SIZE_ADDR = PADDR_W'({REG_TREE_SIZE, 2'b00});

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    t_cmd_word           cmd_word = '0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;

    logic                busy;
    logic                o_result_valid;
    t_result_word        o_result;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    always #(CLK_HALF) i_clk = ~i_clk;

    prefix_sum_tree_top #(
        .MAX_SLOTS      (NUM_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (cmd_word),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_cmd_word       cmd_queue [$];     // words waiting for the driver
    t_result_word    sum_expect [$];    // results owed by the block, oldest first

    // mirror of the block: node counters and the size register
    logic [63:0]     node_sum [NUM_SLOTS];
    logic [SIZE_W-1:0] size_model;

    logic            cmd_taken = 1'b0;  // word accepted at the last rising edge
    int unsigned     send_idle_pct = 0;
    int unsigned     cycle_count   = 0;
    int unsigned     err_count     = 0;
    int unsigned     words_taken   = 0;
    int unsigned     clears_taken  = 0;
    int unsigned     rejects_seen  = 0;
    int unsigned     results_seen  = 0;
    int unsigned     size_writes   = 0;
    t_result_word    want_word;

    // ------------------------------------------------------------------------
    // fenwick tree model: applies one word to the mirror, returns its result
    // ------------------------------------------------------------------------
    function automatic t_result_word fenwick_apply(t_cmd_word w);
        t_result_word r;
        int unsigned  lim;
        int unsigned  pos;
        logic [63:0]  amount;
        logic [63:0]  acc;
        r      = '0;
        // sizes above the slot count behave as the slot count
        lim    = (size_model > NUM_SLOTS) ? NUM_SLOTS : size_model;
        pos    = w.index;
        amount = {{32{w.delta[31]}}, w.delta};
        acc    = '0;
        case (w.command)
            CMD_ADD: begin
                // slot zero and slots at or above the size are refused
                if (pos == 0 || pos >= lim) begin
                    r.status = 1'b1;
                end else begin
                    while (pos != 0 && pos < lim) begin
                        node_sum[pos] = node_sum[pos] + amount;
                        pos = pos + (pos & (~pos + 1));
                    end
                end
            end
            CMD_QUERY: begin
                // a query at slot zero is the empty sum, never refused
                if (pos != 0 && pos >= lim) begin
                    r.status = 1'b1;
                end else begin
                    while (pos != 0) begin
                        acc = acc + node_sum[pos];
                        pos = pos - (pos & (~pos + 1));
                    end
                    r.prefix_sum = acc;
                end
            end
            CMD_CLEAR: begin
                foreach (node_sum[k]) node_sum[k] = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_cmd_word mk_word(logic [1:0] c, int unsigned idx, logic [31:0] d);
        t_cmd_word w;
        w.command = c;
        w.index   = idx[9:0];
        w.delta   = d;
        return w;
    endfunction

    // random word: mostly adds and queries inside the live range, some noise
    function automatic t_cmd_word rand_word(int unsigned lim);
        t_cmd_word   w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            w.command = CMD_ADD;
        end else if (pick < 93) begin
            w.command = CMD_QUERY;
        end else if (pick < 96) begin
            w.command = CMD_CLEAR;
        end else begin
            w.command = CMD_UNUSED;
        end
        if (lim >= 2 && $urandom_range(0, 99) < 85) begin
            w.index = 10'($urandom_range(1, lim - 1));
        end else begin
            w.index = 10'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            case ($urandom_range(0, 3))
                0:       w.delta = 32'h7FFF_FFFF;
                1:       w.delta = 32'h8000_0000;
                2:       w.delta = 32'hFFFF_FFFF;
                default: w.delta = 32'h0000_0001;
            endcase
        end else if (pick < 40) begin
            w.delta = int'($urandom_range(0, 200)) - 100;
        end else begin
            w.delta = $urandom;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // driver: presents queued words at the falling edge, holds each word
    // until the block takes it, and idles at random between words
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cmd_word <= cmd_queue.pop_front();
                start    <= 1'b1;
            end else begin
                start    <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: at each rising edge checks a result word against the oldest
    // expectation, tracks register writes and predicts every accepted word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sum_expect.size());
            $display("FAIL");
            $finish;
        end else if (!i_rst_n) begin
            // mirror follows the reset state of the block
            size_model = TREE_SIZE_RESET;
            foreach (node_sum[k]) node_sum[k] = '0;
            cmd_taken  = 1'b0;
        end else begin
            // a result belongs to a word taken at an earlier edge, so check first
            if (o_result_valid) begin
                results_seen = results_seen + 1;
                if (o_result.status) rejects_seen = rejects_seen + 1;
                if (sum_expect.size() == 0) begin
                    $error("result word with nothing outstanding: prefix_sum %0d status %0b",
                           o_result.prefix_sum, o_result.status);
                    err_count = err_count + 1;
                end else begin
                    want_word = sum_expect.pop_front();
                    if (o_result.prefix_sum !== want_word.prefix_sum) begin
                        $error("prefix_sum: expected %0d, got %0d",
                               want_word.prefix_sum, o_result.prefix_sum);
                        err_count = err_count + 1;
                    end
                    if (o_result.status !== want_word.status) begin
                        $error("status: expected %0b, got %0b",
                               want_word.status, o_result.status);
                        err_count = err_count + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == SIZE_ADDR) begin
                size_model = pwdata[SIZE_W-1:0];
            end
            cmd_taken = start && !busy;
            if (cmd_taken) begin
                words_taken = words_taken + 1;
                if (cmd_word.command == CMD_CLEAR) clears_taken = clears_taken + 1;
                sum_expect.push_back(fenwick_apply(cmd_word));
            end
        end
    end

    // ------------------------------------------------------------------------
    // apb write of tree_size: setup cycle, then access cycle until pready
    // ------------------------------------------------------------------------
    task automatic write_size(input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_writes = size_writes + 1;
    endtask

    // block idle: nothing queued, nothing on the channel, nothing owed
    task automatic wait_drained();
        @(posedge i_clk);
        while (cmd_queue.size() != 0 || start || sum_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    int unsigned phase_size [NUM_PHASES] = '{1024, 17, 2, 2047, 700, 0, 1025, 128, 1024};

    initial begin
        int unsigned lim;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // let the clearing pass after reset run out
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // directed words at the reset size
        send_idle_pct = 21;
        cmd_queue.push_back(mk_word(CMD_QUERY, 0,    32'd0));          // empty sum
        cmd_queue.push_back(mk_word(CMD_QUERY, 1023, 32'd0));          // fresh tree
        cmd_queue.push_back(mk_word(CMD_ADD,   1,    32'h7FFF_FFFF));  // largest delta
        cmd_queue.push_back(mk_word(CMD_ADD,   1023, 32'h8000_0000));  // smallest delta
        cmd_queue.push_back(mk_word(CMD_ADD,   0,    32'd5));          // slot zero refused
        cmd_queue.push_back(mk_word(CMD_ADD,   512,  32'hFFFF_FFFF));
        cmd_queue.push_back(mk_word(CMD_QUERY, 1023, 32'd0));          // sum goes negative
        cmd_queue.push_back(mk_word(CMD_QUERY, 512,  32'd0));
        cmd_queue.push_back(mk_word(CMD_UNUSED, 1023, 32'hFFFF_FFFF)); // ignored
        cmd_queue.push_back(mk_word(CMD_QUERY, 1,    32'd0));
        wait_drained();

        // small tree: the top slot is the first refused one
        write_size(11'd16);
        cmd_queue.push_back(mk_word(CMD_ADD,   16, 32'd7));
        cmd_queue.push_back(mk_word(CMD_ADD,   15, 32'd100));
        cmd_queue.push_back(mk_word(CMD_QUERY, 16, 32'd0));
        cmd_queue.push_back(mk_word(CMD_QUERY, 15, 32'd0));
        wait_drained();

        // sizes below two: no slot valid, query at zero still answered
        write_size(11'd0);
        cmd_queue.push_back(mk_word(CMD_ADD,   1, 32'd3));
        cmd_queue.push_back(mk_word(CMD_QUERY, 0, 32'd0));
        cmd_queue.push_back(mk_word(CMD_QUERY, 1, 32'd0));
        wait_drained();
        write_size(11'd1);
        cmd_queue.push_back(mk_word(CMD_QUERY, 1, 32'd0));
        wait_drained();

        // sizes above the slot count, counters above the old size kept
        write_size(11'd2047);
        cmd_queue.push_back(mk_word(CMD_QUERY, 1023, 32'd0));
        wait_drained();
        write_size(11'd1025);
        cmd_queue.push_back(mk_word(CMD_ADD, 1023, 32'd1));
        wait_drained();

        // smallest useful tree, then a clear
        write_size(11'd2);
        cmd_queue.push_back(mk_word(CMD_ADD,   1, -32'sd5));
        cmd_queue.push_back(mk_word(CMD_ADD,   2, 32'd9));
        cmd_queue.push_back(mk_word(CMD_QUERY, 1, 32'd0));
        cmd_queue.push_back(mk_word(CMD_CLEAR, 0, 32'd0));
        wait_drained();
        write_size(11'd1024);
        cmd_queue.push_back(mk_word(CMD_QUERY, 1023, 32'd0));
        wait_drained();

        // random phases: sender idles 21 %, then 61 %, then not at all
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = (p < 3) ? 21 : (p < 6) ? 61 : 0;
            write_size(phase_size[p][SIZE_W-1:0]);
            lim = (phase_size[p] > NUM_SLOTS) ? NUM_SLOTS : phase_size[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd_queue.push_back(rand_word(lim));
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("covered %0d words (%0d clears), %0d results, %0d refused, %0d size writes",
                 words_taken, clears_taken, results_seen, rejects_seen, size_writes);
        $display("sizes swept from 0 to 2047, sender idling at 21, 61 and 0 percent");
        if (err_count == 0 && sum_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
